@@ design/awbs_pkg.sv @@
// ---------------------------------------------------------------------------
// awbs_pkg
// Shared types and constants for the AWB statistics block screen: grid size,
// divider and multiplier step counts, configuration register indexes, and
// the command/status words between controller and datapath.
// ---------------------------------------------------------------------------
package awbs_pkg;

  // Grid geometry
  localparam int unsigned GridCols    = 32;
  localparam int unsigned GridRowsMax = 64;
  localparam int unsigned PosW        = 6;

  // Field widths
  localparam int unsigned SumW   = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned RatioW = 24;
  localparam int unsigned QuotW  = 48;   // full quotient of (sum << 16) / green
  localparam int unsigned FracW  = 16;
  localparam int unsigned GainFracW = 12;

  // Multiplier split: 36 usable quotient bits in two 18-bit halves
  localparam int unsigned HalfW  = 18;
  localparam int unsigned ProdW  = HalfW + GainW;
  localparam int unsigned SumPW  = 2 * HalfW + GainW;

  // Sequencer step counts
  localparam int unsigned DivSteps = QuotW;
  localparam int unsigned MulSteps = 4;
  localparam int unsigned CntW     = 6;
  localparam int unsigned MulSelW  = 2;

  // Configuration port
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgUpperRed   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgUpperGreen = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgUpperBlue  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgLowerRed   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgLowerGreen = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgLowerBlue  = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgGainRg     = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgGainBg     = 4'd7;

  localparam logic [GainW-1:0] GainUnit = 16'd4096;

  typedef struct packed {
    logic [SumW-1:0]  upper_red;
    logic [SumW-1:0]  upper_green;
    logic [SumW-1:0]  upper_blue;
    logic [SumW-1:0]  lower_red;
    logic [SumW-1:0]  lower_green;
    logic [SumW-1:0]  lower_blue;
    logic [GainW-1:0] gain_rg;
    logic [GainW-1:0] gain_bg;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic               load;      // capture an accepted word, advance position
    logic               div_step;  // one quotient bit for both ratios
    logic               mul_step;  // one partial product
    logic [MulSelW-1:0] mul_sel;   // which partial product
    logic               out_load;  // move the finished result to the output
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic keep;      // word on the input passes all thresholds
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

@@ design/awbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// awbs_ctrl
// Sequencer for one block at a time: accept, and for a kept block 48 divider
// steps, four partial products, then hand the result to the output register.
// ---------------------------------------------------------------------------
module awbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  awbs_pkg::sts_t sts_i,
  output awbs_pkg::cmd_t cmd_o
);
  import awbs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.keep) begin
          state_d = StDiv;
          cnt_d   = '0;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StMul;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = cnt_q[MulSelW-1:0];
        if (cnt_q == CntW'(MulSteps - 1)) begin
          state_d = StOut;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/awbs_dpath.sv @@
// ---------------------------------------------------------------------------
// awbs_dpath
// Datapath: threshold screen, grid position, two bit-serial dividers sharing
// the green denominator, one shared 18x16 multiplier, and the output register.
// ---------------------------------------------------------------------------
module awbs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  awbs_pkg::cfg_t                      cfg_i,
  input  logic [awbs_pkg::SumW-1:0]           red_sum_i,
  input  logic [awbs_pkg::SumW-1:0]           green_sum_i,
  input  logic [awbs_pkg::SumW-1:0]           blue_sum_i,
  input  logic [awbs_pkg::SumW-1:0]           luma_level_i,
  input  logic                                frame_last_i,
  input  awbs_pkg::cmd_t                      cmd_i,
  output awbs_pkg::sts_t                      sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [awbs_pkg::PosW-1:0]           grid_row_o,
  output logic [awbs_pkg::PosW-1:0]           grid_col_o,
  output logic [awbs_pkg::RatioW-1:0]         ratio_rg_o,
  output logic [awbs_pkg::RatioW-1:0]         ratio_bg_o,
  output logic [awbs_pkg::RatioW-1:0]         corrected_rg_o,
  output logic [awbs_pkg::RatioW-1:0]         corrected_bg_o,
  output logic [awbs_pkg::SumW-1:0]           luma_out_o
);
  import awbs_pkg::*;

  localparam logic [RatioW-1:0] Sat = {RatioW{1'b1}};

  // Grid position
  logic [PosW-1:0] row_q, col_q;
  logic [PosW-1:0] pos_row_q, pos_col_q;

  // Divider state
  logic [SumW-1:0]  den_q;
  logic [SumW-1:0]  rem_r_q, rem_b_q;
  logic [QuotW-1:0] dq_r_q, dq_b_q;
  logic [SumW-1:0]  luma_q;

  // Partial products: red low, red high, blue low, blue high
  logic [ProdW-1:0] prod_q [MulSteps];

  // Output register
  logic             out_valid_q;
  logic [PosW-1:0]  grid_row_q, grid_col_q;
  logic [RatioW-1:0] ratio_rg_q, ratio_bg_q, corr_rg_q, corr_bg_q;
  logic [SumW-1:0]  luma_out_q;

  // Screen the incoming word against the thresholds
  always_comb begin
    sts_o.keep = (red_sum_i   >= cfg_i.lower_red)   && (red_sum_i   <= cfg_i.upper_red)   &&
                 (green_sum_i >= cfg_i.lower_green) && (green_sum_i <= cfg_i.upper_green) &&
                 (blue_sum_i  >= cfg_i.lower_blue)  && (blue_sum_i  <= cfg_i.upper_blue);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Advance the grid position for every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.load) begin
      if (frame_last_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (col_q == PosW'(GridCols - 1)) begin
        col_q <= '0;
        row_q <= (row_q == PosW'(GridRowsMax - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // One restoring-division step for each ratio
  logic [SumW:0]   rsh_r, rsh_b;
  logic            ge_r, ge_b;
  logic [SumW:0]   rsub_r, rsub_b;

  always_comb begin
    rsh_r  = {rem_r_q, dq_r_q[QuotW-1]};
    rsh_b  = {rem_b_q, dq_b_q[QuotW-1]};
    ge_r   = rsh_r >= {1'b0, den_q};
    ge_b   = rsh_b >= {1'b0, den_q};
    rsub_r = rsh_r - {1'b0, den_q};
    rsub_b = rsh_b - {1'b0, den_q};
  end

  // Shared multiplier: pick a quotient half and its gain
  logic [HalfW-1:0] mul_a;
  logic [GainW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;

  always_comb begin
    case (cmd_i.mul_sel)
      2'd0:    begin mul_a = dq_r_q[HalfW-1:0];       mul_b = cfg_i.gain_rg; end
      2'd1:    begin mul_a = dq_r_q[2*HalfW-1:HalfW]; mul_b = cfg_i.gain_rg; end
      2'd2:    begin mul_a = dq_b_q[HalfW-1:0];       mul_b = cfg_i.gain_bg; end
      default: begin mul_a = dq_b_q[2*HalfW-1:HalfW]; mul_b = cfg_i.gain_bg; end
    endcase
    mul_p = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // Capture, divide and multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      den_q     <= green_sum_i;
      rem_r_q   <= '0;
      rem_b_q   <= '0;
      dq_r_q    <= {red_sum_i, {FracW{1'b0}}};
      dq_b_q    <= {blue_sum_i, {FracW{1'b0}}};
      luma_q    <= luma_level_i;
      pos_row_q <= row_q;
      pos_col_q <= col_q;
    end else if (cmd_i.div_step) begin
      rem_r_q <= ge_r ? rsub_r[SumW-1:0] : rsh_r[SumW-1:0];
      rem_b_q <= ge_b ? rsub_b[SumW-1:0] : rsh_b[SumW-1:0];
      dq_r_q  <= {dq_r_q[QuotW-2:0], ge_r};
      dq_b_q  <= {dq_b_q[QuotW-2:0], ge_b};
    end
    if (cmd_i.mul_step) begin
      prod_q[cmd_i.mul_sel] <= mul_p;
    end
  end

  // Assemble ratios and corrected values with saturation
  logic             den_zero;
  logic [SumPW-1:0] sum_r, sum_b;
  logic             big_r, big_b;
  logic [RatioW-1:0] ratio_rg_d, ratio_bg_d, corr_rg_d, corr_bg_d;

  always_comb begin
    den_zero = (den_q == '0);
    sum_r = {prod_q[1], {HalfW{1'b0}}} + SumPW'(prod_q[0]);
    sum_b = {prod_q[3], {HalfW{1'b0}}} + SumPW'(prod_q[2]);
    // Quotient of 2^36 or more with any nonzero gain always saturates
    big_r = (dq_r_q[QuotW-1:2*HalfW] != '0) && (cfg_i.gain_rg != '0);
    big_b = (dq_b_q[QuotW-1:2*HalfW] != '0) && (cfg_i.gain_bg != '0);

    ratio_rg_d = (den_zero || dq_r_q[QuotW-1:RatioW] != '0) ? Sat : dq_r_q[RatioW-1:0];
    ratio_bg_d = (den_zero || dq_b_q[QuotW-1:RatioW] != '0) ? Sat : dq_b_q[RatioW-1:0];
    corr_rg_d  = (den_zero || big_r || sum_r[SumPW-1:RatioW+GainFracW] != '0) ?
                 Sat : sum_r[RatioW+GainFracW-1:GainFracW];
    corr_bg_d  = (den_zero || big_b || sum_b[SumPW-1:RatioW+GainFracW] != '0) ?
                 Sat : sum_b[RatioW+GainFracW-1:GainFracW];
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      grid_row_q <= pos_row_q;
      grid_col_q <= pos_col_q;
      ratio_rg_q <= ratio_rg_d;
      ratio_bg_q <= ratio_bg_d;
      corr_rg_q  <= corr_rg_d;
      corr_bg_q  <= corr_bg_d;
      luma_out_q <= luma_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grid_row_o     = grid_row_q;
  assign grid_col_o     = grid_col_q;
  assign ratio_rg_o     = ratio_rg_q;
  assign ratio_bg_o     = ratio_bg_q;
  assign corrected_rg_o = corr_rg_q;
  assign corrected_bg_o = corr_bg_q;
  assign luma_out_o     = luma_out_q;

endmodule

@@ design/awb_stats_block_screen_top.sv @@
// ---------------------------------------------------------------------------
// awb_stats_block_screen_top
// AWB grey-world statistics block screen: drops blocks outside the channel
// thresholds and reports R/G, B/G and gain-corrected ratios of kept blocks.
//
//   channel  handshake                 payload
//   -------  ------------------------  --------------------------------------
//   in       in_valid_i / in_stall_o   red/green/blue sums, luma, frame_last
//   out      out_valid_o / out_stall_i grid position, ratios, corrected, luma
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A dropped block is only accepted. A kept block is accepted, then stalls the input
// through the bit-serial dividers (one quotient bit per cycle, both ratios in
// parallel), the shared 18x16 multiplier and the load of the output register.
// Reset clears the grid position and loads the register defaults.
// A result waiting in the output register does not block the next block;
// only the load of a further result waits for the output to drain.
// ---------------------------------------------------------------------------
module awb_stats_block_screen_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [awbs_pkg::SumW-1:0]         red_sum_i,
  input  logic [awbs_pkg::SumW-1:0]         green_sum_i,
  input  logic [awbs_pkg::SumW-1:0]         blue_sum_i,
  input  logic [awbs_pkg::SumW-1:0]         luma_level_i,
  input  logic                              frame_last_i,
  // Result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [awbs_pkg::PosW-1:0]         grid_row_o,
  output logic [awbs_pkg::PosW-1:0]         grid_col_o,
  output logic [awbs_pkg::RatioW-1:0]       ratio_rg_o,
  output logic [awbs_pkg::RatioW-1:0]       ratio_bg_o,
  output logic [awbs_pkg::RatioW-1:0]       corrected_rg_o,
  output logic [awbs_pkg::RatioW-1:0]       corrected_bg_o,
  output logic [awbs_pkg::SumW-1:0]         luma_out_o,
  // Register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [awbs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [awbs_pkg::SumW-1:0]         cfg_data_i
);
  import awbs_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_red   <= '1;
      cfg_q.upper_green <= '1;
      cfg_q.upper_blue  <= '1;
      cfg_q.lower_red   <= '0;
      cfg_q.lower_green <= '0;
      cfg_q.lower_blue  <= '0;
      cfg_q.gain_rg     <= GainUnit;
      cfg_q.gain_bg     <= GainUnit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgUpperRed:   cfg_q.upper_red   <= cfg_data_i;
        CfgUpperGreen: cfg_q.upper_green <= cfg_data_i;
        CfgUpperBlue:  cfg_q.upper_blue  <= cfg_data_i;
        CfgLowerRed:   cfg_q.lower_red   <= cfg_data_i;
        CfgLowerGreen: cfg_q.lower_green <= cfg_data_i;
        CfgLowerBlue:  cfg_q.lower_blue  <= cfg_data_i;
        CfgGainRg:     cfg_q.gain_rg     <= cfg_data_i[GainW-1:0];
        CfgGainBg:     cfg_q.gain_bg     <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  awbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  awbs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .red_sum_i      (red_sum_i),
    .green_sum_i    (green_sum_i),
    .blue_sum_i     (blue_sum_i),
    .luma_level_i   (luma_level_i),
    .frame_last_i   (frame_last_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .grid_row_o     (grid_row_o),
    .grid_col_o     (grid_col_o),
    .ratio_rg_o     (ratio_rg_o),
    .ratio_bg_o     (ratio_bg_o),
    .corrected_rg_o (corrected_rg_o),
    .corrected_bg_o (corrected_bg_o),
    .luma_out_o     (luma_out_o)
  );

  // A capture only happens on an accepted input word
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && !in_stall_o))
    else $error("capture without an accepted input word");

  // A kept block makes the input stall while it is worked on
  a_kept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.keep) |=> in_stall_o)
    else $error("input not stalled after a kept block");

  // A new result appears only after a load from the sequencer
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the AWB statistics block screen. Drives statistics
// blocks through the valid/stall input, predicts the kept blocks (grid
// position, R/G and B/G ratios, gain-corrected ratios, luma) and compares
// every result word field by field. Covers the reset registers, thresholds at
// their bounds, crossed thresholds, gain extremes, unused register indexes,
// column wraps across several rows, and random phases under several register
// settings.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awbs_pkg::*;

  localparam int DrainCycles = 64;
  localparam int IdlePct     = 16;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = 4'd8;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
    logic [SumW-1:0] luma;
    logic            last;
  } block_t;

  typedef struct packed {
    logic [PosW-1:0]   row;
    logic [PosW-1:0]   col;
    logic [RatioW-1:0] rg;
    logic [RatioW-1:0] bg;
    logic [RatioW-1:0] corr_rg;
    logic [RatioW-1:0] corr_bg;
    logic [SumW-1:0]   luma;
  } result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [SumW-1:0]     red_sum_i    = '0;
  logic [SumW-1:0]     green_sum_i  = '0;
  logic [SumW-1:0]     blue_sum_i   = '0;
  logic [SumW-1:0]     luma_level_i = '0;
  logic                frame_last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [PosW-1:0]     grid_row_o;
  logic [PosW-1:0]     grid_col_o;
  logic [RatioW-1:0]   ratio_rg_o;
  logic [RatioW-1:0]   ratio_bg_o;
  logic [RatioW-1:0]   corrected_rg_o;
  logic [RatioW-1:0]   corrected_bg_o;
  logic [SumW-1:0]     luma_out_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [SumW-1:0]     cfg_data_i   = '0;

  // Screen registers and grid position as the block should hold them
  cfg_t            screen_cfg;
  logic [PosW-1:0] pos_row = '0;
  logic [PosW-1:0] pos_col = '0;
  result_t         kept_q[$];
  int              fail_count = 0;
  bit              idling_on  = 1'b1;

  awb_stats_block_screen_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_sum_i      (red_sum_i),
    .green_sum_i    (green_sum_i),
    .blue_sum_i     (blue_sum_i),
    .luma_level_i   (luma_level_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .grid_row_o     (grid_row_o),
    .grid_col_o     (grid_col_o),
    .ratio_rg_o     (ratio_rg_o),
    .ratio_bg_o     (ratio_bg_o),
    .corrected_rg_o (corrected_rg_o),
    .corrected_bg_o (corrected_bg_o),
    .luma_out_o     (luma_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= idling_on && ($urandom_range(99) < IdlePct);
  end

  // ---- prediction ----

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.upper_red   = '1;
    c.upper_green = '1;
    c.upper_blue  = '1;
    c.lower_red   = '0;
    c.lower_green = '0;
    c.lower_blue  = '0;
    c.gain_rg     = GainUnit;
    c.gain_bg     = GainUnit;
    return c;
  endfunction

  // Q8.16 quotient and its gain-corrected value, both saturated to 24 bits
  function automatic void color_ratio(input logic [SumW-1:0] num, den,
                                      input logic [GainW-1:0] gain,
                                      output logic [RatioW-1:0] ratio, corr);
    logic [63:0] quot;
    logic [63:0] prod;
    if (den == '0) begin
      ratio = '1;
      corr  = '1;
    end else begin
      quot  = {16'h0, num, 16'h0} / {32'h0, den};
      ratio = (quot > 64'hFF_FFFF) ? '1 : quot[RatioW-1:0];
      prod  = (quot * {48'h0, gain}) >> GainFracW;
      corr  = (prod > 64'hFF_FFFF) ? '1 : prod[RatioW-1:0];
    end
  endfunction

  // Screen one accepted word, queue its result if kept, then step the grid
  function automatic void screen_block(input block_t b);
    result_t r;
    if (b.red   >= screen_cfg.lower_red   && b.red   <= screen_cfg.upper_red   &&
        b.green >= screen_cfg.lower_green && b.green <= screen_cfg.upper_green &&
        b.blue  >= screen_cfg.lower_blue  && b.blue  <= screen_cfg.upper_blue) begin
      r.row  = pos_row;
      r.col  = pos_col;
      r.luma = b.luma;
      color_ratio(b.red, b.green, screen_cfg.gain_rg, r.rg, r.corr_rg);
      color_ratio(b.blue, b.green, screen_cfg.gain_bg, r.bg, r.corr_bg);
      kept_q.push_back(r);
    end
    if (b.last) begin
      pos_row = '0;
      pos_col = '0;
    end else if (pos_col == GridCols - 1) begin
      pos_col = '0;
      pos_row = (pos_row == GridRowsMax - 1) ? '0 : pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endfunction

  // ---- result checking ----

  function automatic void check_field(input string name, input logic [SumW-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_q.size() == 0) begin
        $error("result word with nothing expected: row %0d col %0d", grid_row_o, grid_col_o);
        fail_count++;
      end else begin
        want = kept_q.pop_front();
        check_field("grid_row", SumW'(want.row), SumW'(grid_row_o));
        check_field("grid_col", SumW'(want.col), SumW'(grid_col_o));
        check_field("ratio_rg", SumW'(want.rg), SumW'(ratio_rg_o));
        check_field("ratio_bg", SumW'(want.bg), SumW'(ratio_bg_o));
        check_field("corrected_rg", SumW'(want.corr_rg), SumW'(corrected_rg_o));
        check_field("corrected_bg", SumW'(want.corr_bg), SumW'(corrected_bg_o));
        check_field("luma_out", want.luma, luma_out_o);
      end
    end
  end

  // ---- drivers ----

  // Present one word at the falling edge and hold it until accepted
  task automatic send_block(input block_t b);
    while (idling_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    red_sum_i    <= b.red;
    green_sum_i  <= b.green;
    blue_sum_i   <= b.blue;
    luma_level_i <= b.luma;
    frame_last_i <= b.last;
    do @(posedge clk_i); while (in_stall_o);
    screen_block(b);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every pending result, then let the block settle
  task automatic drain_results(input int settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (kept_q.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // One register write; the caller drops cfg_valid_i after the last one
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [SumW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgUpperRed:   screen_cfg.upper_red   = data;
      CfgUpperGreen: screen_cfg.upper_green = data;
      CfgUpperBlue:  screen_cfg.upper_blue  = data;
      CfgLowerRed:   screen_cfg.lower_red   = data;
      CfgLowerGreen: screen_cfg.lower_green = data;
      CfgLowerBlue:  screen_cfg.lower_blue  = data;
      CfgGainRg:     screen_cfg.gain_rg     = data[GainW-1:0];
      CfgGainBg:     screen_cfg.gain_bg     = data[GainW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    drain_results(DrainCycles);
    cfg_write(CfgUpperRed,   c.upper_red);
    cfg_write(CfgUpperGreen, c.upper_green);
    cfg_write(CfgUpperBlue,  c.upper_blue);
    cfg_write(CfgLowerRed,   c.lower_red);
    cfg_write(CfgLowerGreen, c.lower_green);
    cfg_write(CfgLowerBlue,  c.lower_blue);
    // upper data bits are don't-care for the gains
    cfg_write(CfgGainRg, {16'($urandom), c.gain_rg});
    cfg_write(CfgGainBg, {16'($urandom), c.gain_bg});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic block_t mk_block(input logic [SumW-1:0] r, g, b, y, input logic last);
    block_t blk;
    blk.red   = r;
    blk.green = g;
    blk.blue  = b;
    blk.luma  = y;
    blk.last  = last;
    return blk;
  endfunction

  // ---- random content ----

  function automatic logic [SumW-1:0] rand_sum();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(255);
      3:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // Sum related to green so the ratios spread over the Q8.16 range
  function automatic logic [SumW-1:0] near_green(input logic [SumW-1:0] g);
    case ($urandom_range(2))
      0:       return g >> $urandom_range(20);
      1:       return (g << $urandom_range(8)) ^ $urandom_range(255);
      default: return g + $urandom_range(1023);
    endcase
  endfunction

  // Pull most values into the threshold window; leave some outside
  function automatic logic [SumW-1:0] fit_window(input logic [SumW-1:0] v, lo, hi);
    logic [63:0] span;
    if (lo > hi || (v >= lo && v <= hi) || $urandom_range(4) == 0) return v;
    span = {32'h0, hi} - {32'h0, lo} + 64'd1;
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return lo + SumW'({$urandom, $urandom} % span);
    endcase
  endfunction

  function automatic block_t rand_block();
    block_t b;
    b.green = rand_sum();
    b.red   = $urandom_range(1) ? near_green(b.green) : rand_sum();
    b.blue  = $urandom_range(1) ? near_green(b.green) : rand_sum();
    b.luma  = $urandom_range(3) ? $urandom : rand_sum();
    b.last  = ($urandom_range(24) == 0);
    b.red   = fit_window(b.red,   screen_cfg.lower_red,   screen_cfg.upper_red);
    b.green = fit_window(b.green, screen_cfg.lower_green, screen_cfg.upper_green);
    b.blue  = fit_window(b.blue,  screen_cfg.lower_blue,  screen_cfg.upper_blue);
    return b;
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return GainUnit;
      default: return GainW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    logic [SumW-1:0] lo[3];
    logic [SumW-1:0] hi[3];
    logic [SumW-1:0] a, b;
    for (int ch = 0; ch < 3; ch++) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3: begin lo[ch] = '0; hi[ch] = '1; end
        4:          begin lo[ch] = '0; hi[ch] = '0; end
        5:          begin lo[ch] = '1; hi[ch] = '1; end
        6, 7:       begin lo[ch] = (a < b) ? a : b; hi[ch] = (a < b) ? b : a; end
        8:          begin lo[ch] = $urandom_range(4095); hi[ch] = '1 - $urandom_range(4095); end
        default:    begin lo[ch] = a | 32'h1; hi[ch] = lo[ch] - 1; end
      endcase
    end
    c.lower_red   = lo[0];
    c.upper_red   = hi[0];
    c.lower_green = lo[1];
    c.upper_green = hi[1];
    c.lower_blue  = lo[2];
    c.upper_blue  = hi[2];
    c.gain_rg     = rand_gain();
    c.gain_bg     = rand_gain();
    return c;
  endfunction

  // ---- tests ----

  // Reset registers: green zero, ratio bounds, saturation edge, frame end
  task automatic test_reset_values();
    send_block(mk_block('0, '0, '0, '0, 1'b0));
    send_block(mk_block('1, 32'd1, '1, '1, 1'b0));
    send_block(mk_block(32'd1000, 32'd1000, 32'd500, 32'h1234_5678, 1'b0));
    send_block(mk_block(32'd1, '1, '0, '0, 1'b0));
    send_block(mk_block(32'h00FF_FFFF, 32'h0001_0000, 32'h0100_0000, 32'hA5A5_5A5A, 1'b0));
    send_block(mk_block('1, '1, '1, '1, 1'b1));
    send_block(mk_block(32'd7, '0, 32'd9, 32'd3, 1'b0));
  endtask

  // Each channel at its lower and upper bound and one step past each
  task automatic test_thresholds();
    cfg_t c;
    logic [SumW-1:0] probe[4];
    probe = '{32'd999, 32'd1000, 32'd2000, 32'd2001};
    for (int ch = 0; ch < 3; ch++) begin
      c = default_cfg();
      case (ch)
        0:       begin c.lower_red   = 32'd1000; c.upper_red   = 32'd2000; end
        1:       begin c.lower_green = 32'd1000; c.upper_green = 32'd2000; end
        default: begin c.lower_blue  = 32'd1000; c.upper_blue  = 32'd2000; end
      endcase
      load_config(c);
      foreach (probe[k]) begin
        case (ch)
          0:       send_block(mk_block(probe[k], 32'd1500, 32'd1500, probe[k], 1'b0));
          1:       send_block(mk_block(32'd1500, probe[k], 32'd1500, probe[k], 1'b0));
          default: send_block(mk_block(32'd1500, 32'd1500, probe[k], probe[k], 1'b0));
        endcase
      end
    end
  endtask

  // Lower bound above upper drops everything; the grid still advances
  task automatic test_crossed_window();
    cfg_t c;
    c = default_cfg();
    c.lower_green = 32'd5000;
    c.upper_green = 32'd4999;
    load_config(c);
    send_block(mk_block(32'd10, 32'd4999, 32'd10, 32'd1, 1'b0));
    send_block(mk_block(32'd10, 32'd5000, 32'd10, 32'd2, 1'b0));
    load_config(default_cfg());
    send_block(mk_block(32'd10, 32'd5000, 32'd10, 32'd3, 1'b0));
  endtask

  // Zero and full-scale gains against huge, small and undefined quotients
  task automatic test_gain_extremes();
    cfg_t c;
    c = default_cfg();
    c.gain_rg = '0;
    c.gain_bg = '1;
    load_config(c);
    send_block(mk_block('1, 32'd1, '1, 32'd11, 1'b0));
    send_block(mk_block('0, '0, 32'd5, 32'd12, 1'b0));
    send_block(mk_block(32'd3, 32'd2, 32'd200, 32'd13, 1'b0));
    send_block(mk_block(32'd1, 32'h0001_0000, 32'd1, 32'd14, 1'b0));
  endtask

  // Writes past the register list leave the screen untouched
  task automatic test_unused_index();
    load_config(default_cfg());
    @(negedge clk_i);
    for (int i = 0; i < 8; i++) cfg_write(CfgIdxW'(CfgFirstUnused + i), $urandom);
    cfg_valid_i <= 1'b0;
    send_block(mk_block(32'd300, 32'd200, 32'd100, '1, 1'b0));
  endtask

  // Long frame with no end marker: wraps the columns over several rows
  task automatic test_grid_wrap();
    cfg_t c;
    block_t b;
    bit corner;
    c = default_cfg();
    c.lower_red = 32'd16;
    load_config(c);
    for (int n = 0; n < 100; n++) begin
      corner = (pos_col == 0 || pos_col == GridCols - 1) &&
               (pos_row <= 1 || pos_row >= GridRowsMax - 2);
      b = rand_block();
      b.last = 1'b0;
      b.red  = (corner || $urandom_range(99) < 3) ? 32'd16 + $urandom_range(1000)
                                                   : $urandom_range(15);
      send_block(b);
    end
    // end the frame mid-row and restart at the origin
    send_block(mk_block(32'd100, 32'd50, 32'd25, 32'd1, 1'b1));
    send_block(mk_block(32'd100, 32'd50, 32'd25, 32'd2, 1'b0));
    send_block(mk_block(32'd100, 32'd50, 32'd25, 32'd3, 1'b0));
  endtask

  // Random phases, each under its own register setting
  task automatic test_random_phases();
    cfg_t c;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       c = default_cfg();
        1:       begin c = default_cfg(); c.gain_rg = '1; c.gain_bg = '0; end
        default: c = rand_cfg();
      endcase
      load_config(c);
      // one phase runs without any idling on either side
      idling_on = (phase != 3);
      for (int n = 0; n < 75; n++) begin
        send_block(rand_block());
        if ($urandom_range(59) == 0) drain_results(0);
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    screen_cfg = default_cfg();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_thresholds();
    test_crossed_window();
    test_gain_extremes();
    test_unused_index();
    test_random_phases();
    test_grid_wrap();
    drain_results(DrainCycles);
    if (fail_count == 0 && kept_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
